>>> design/fp64_scale_by_power_of_two_unit_assert.svh
// Assertion macros for the fp64 scale unit.
`ifndef FP64_SCALE_BY_POWER_OF_TWO_UNIT_ASSERT_SVH
`define FP64_SCALE_BY_POWER_OF_TWO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define FSU_ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("lbl");
`define FSU_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");
`else
`define FSU_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define FSU_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> design/fp64s_pkg.sv
package fp64s_pkg;
    localparam int FRAC_W = 52;
    localparam int EXP_W = 11;
    localparam logic [EXP_W-1:0] EXP_ALL_ONE = 11'h7ff;
    localparam int SCALE_LIMIT = 2200;
    // signed exponent wide enough for -2251..4246
    localparam int E_W = 14;

    // stage 1 -> stage 2
    typedef struct packed {
        logic              sign;
        logic              pass;     // NaN, inf or zero: return input
        logic [63:0]       raw;
        logic [FRAC_W:0]   sig;      // hidden bit set for normal inputs, clear for subnormals
        logic signed [E_W-1:0] e;    // unbiased-by-scale exponent
        logic [5:0]        lz;       // leading zeros of a subnormal fraction; the shift is lz + 1
        logic signed [E_W-1:0] n;    // clamped scale
    } t_st1;

    // stage 2 -> stage 3
    typedef struct packed {
        logic              sign;
        logic              pass;
        logic [63:0]       raw;
        logic [FRAC_W:0]   sig;
        logic signed [E_W-1:0] e;
    } t_st2;
endpackage

>>> design/fp64s_unpack.sv
// Stage 1: unpack, count leading zeros of a subnormal, clamp the scale.
module fp64s_unpack (
    input  logic [63:0]          i_bits,
    input  logic signed [31:0]   i_n,
    output fp64s_pkg::t_st1      o_st
);
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  lz;

    assign bexp = i_bits[62:52];
    assign frac = i_bits[51:0];

    // leading zero count of fraction (priority search)
    always_comb begin
        lz = 6'd0;
        for (int k = 0; k < 52; k++) begin
            if (frac[k]) lz = 6'(51 - k);
        end
    end

    always_comb begin
        o_st.sign = i_bits[63];
        o_st.raw  = i_bits;
        o_st.pass = (bexp == fp64s_pkg::EXP_ALL_ONE) || (bexp == 11'd0 && frac == 52'd0);
        o_st.lz   = lz;
        if (bexp == 11'd0) begin
            o_st.sig = {1'b0, frac};
            o_st.e   = 14'sd1;
        end else begin
            o_st.sig = {1'b1, frac};
            o_st.e   = $signed({3'b000, bexp});
        end
        if (i_n > fp64s_pkg::SCALE_LIMIT)       o_st.n = 14'(fp64s_pkg::SCALE_LIMIT);
        else if (i_n < -fp64s_pkg::SCALE_LIMIT) o_st.n = 14'(-fp64s_pkg::SCALE_LIMIT);
        else                                    o_st.n = i_n[13:0];
    end
endmodule

>>> design/fp64s_norm.sv
// Stage 2: shift subnormal left and add the scale.
module fp64s_norm (
    input  fp64s_pkg::t_st1 i_st,
    output fp64s_pkg::t_st2 o_st
);
    logic is_sub;
    assign is_sub = ~i_st.sig[52];

    always_comb begin
        o_st.sign = i_st.sign;
        o_st.pass = i_st.pass;
        o_st.raw  = i_st.raw;
        if (is_sub) begin
            // shifting by lz + 1 lowers the exponent by the same amount
            o_st.sig = i_st.sig << (i_st.lz + 6'd1);
            o_st.e   = i_st.e - $signed({8'd0, i_st.lz}) - 14'sd1 + i_st.n;
        end else begin
            o_st.sig = i_st.sig;
            o_st.e   = i_st.e + i_st.n;
        end
    end
endmodule

>>> design/fp64s_round.sv
// Stage 3: pass, saturate, pack normals, or denormalize and round (RNE).
module fp64s_round (
    input  fp64s_pkg::t_st2 i_st,
    output logic [63:0]     o_bits
);
    logic [5:0]  s;
    logic [52:0] q;
    logic [52:0] rem;
    logic [52:0] half;
    logic [52:0] qr;

    always_comb begin
        s    = 6'(14'sd1 - i_st.e);
        q    = i_st.sig >> s;
        rem  = i_st.sig & ((53'd1 << s) - 53'd1);
        half = 53'd1 << (s - 6'd1);
        qr   = q + {52'd0, (rem > half) || (rem == half && q[0])};
        if (i_st.pass) begin
            o_bits = i_st.raw;
        end else if (i_st.e >= 14'sd2047) begin
            o_bits = {i_st.sign, fp64s_pkg::EXP_ALL_ONE, 52'd0};
        end else if (i_st.e >= 14'sd1) begin
            o_bits = {i_st.sign, i_st.e[10:0], i_st.sig[51:0]};
        end else if (i_st.e <= -14'sd53) begin
            o_bits = {i_st.sign, 63'd0};
        end else begin
            o_bits = {i_st.sign, 10'd0, qr};
        end
    end
endmodule

>>> design/fp64_scale_by_power_of_two_unit.sv
// Binary64 scale by power of two (ldexp) with round to nearest-even.
// Input beat: s_axis tdata = {scale_exponent[31:0], value_bits[63:0]}.
// Output beat: m_axis tdata = result_bits.
// One beat accepted per cycle when the output is not stalled.
// Three register stages: unpack/clamp, normalize/add exponent,
// round/pack.
// NaN, infinity and zero pass unchanged; overflow gives signed infinity;
// underflow rounds to subnormal or signed zero.
// Reset clears all valid bits; payload is not reset.
// On output stall the pipeline holds; s_axis_tready falls only while the
// last stage is full and stalled and every stage ahead of it is full.
// Each stage advances when its successor is empty or moving.
module fp64_scale_by_power_of_two_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // [63:0] value_bits, [95:64] scale_exponent
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata    // [63:0] result_bits
);
    `include "fp64_scale_by_power_of_two_unit_assert.svh"

    fp64s_pkg::t_st1 n_st1, r_st1;
    fp64s_pkg::t_st2 n_st2, r_st2;
    logic [63:0]     n_out, r_out;
    logic            r_v1, r_v2, r_v3;
    logic            adv1, adv2, adv3;

    assign adv3 = ~r_v3 | m_axis_tready;
    assign adv2 = ~r_v2 | adv3;
    assign adv1 = ~r_v1 | adv2;
    assign s_axis_tready = adv1;

    fp64s_unpack u_unpack (
        .i_bits (s_axis_tdata[63:0]),
        .i_n    ($signed(s_axis_tdata[95:64])),
        .o_st   (n_st1)
    );
    fp64s_norm u_norm (.i_st(r_st1), .o_st(n_st2));
    fp64s_round u_round (.i_st(r_st2), .o_bits(n_out));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv1) r_st1 <= n_st1;
        if (adv2) r_st2 <= n_st2;
        if (adv3) r_out <= n_out;
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_out;

    `FSU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v3 && !m_axis_tready, r_v3 && $stable(r_out))
    `FSU_ASSERT_IMPL(a_ready_full, i_clk, i_rst_n, !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
    `FSU_ASSERT_NEXT(a_v2_moves, i_clk, i_rst_n, r_v2 && adv3, r_v3)
endmodule
